>>> hdl/pbb_pkg.sv
`default_nettype none
package pbb_pkg;

  localparam int MAX_SAMPLES = 1024;
  localparam int MAX_EDGES   = 16;
  localparam int MULT_BITS   = 16;
  localparam int MAX_BINS    = MAX_EDGES - 1;
  localparam int ADDR_BITS   = $clog2(MAX_SAMPLES);
  localparam int CNT_BITS    = $clog2(MAX_SAMPLES + 1);
  localparam int QDEPTH      = 4;
  localparam int QPTR_BITS   = $clog2(QDEPTH);

  typedef enum logic [1:0] {
    CMD_ADD      = 2'd0,
    CMD_BUILD    = 2'd1,
    CMD_CLASSIFY = 2'd2,
    CMD_NONE     = 2'd3
  } cmd_t;

  typedef enum logic [1:0] {
    REG_EDGE_COUNT = 2'd0,
    REG_EDGE_A     = 2'd1,
    REG_EDGE_B     = 2'd2,
    REG_NONE       = 2'd3
  } reg_idx_t;

  typedef struct packed {
    logic [1:0]  cmd;
    logic [15:0] multiplicity;
  } in_item_t;

  typedef struct packed {
    logic        kind;
    logic [3:0]  bin_index;
    logic        found;
    logic [6:0]  pct_low;
    logic [6:0]  pct_high;
    logic [7:0]  pct_mid_twice;
    logic [15:0] bound_high;
    logic [15:0] bound_low;
    logic        sample_overflow;
    logic        last;
  } out_item_t;

  // decoded command handed from front to back
  typedef struct packed {
    cmd_t        cmd;
    logic [15:0] value;
  } job_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_SORT_RD,
    ST_SORT_CMP,
    ST_SORT_SHIFT,
    ST_SORT_PUT,
    ST_BIN_IDX,
    ST_BIN_MUL,
    ST_BIN_DIV,
    ST_BIN_RD,
    ST_BIN_EMIT,
    ST_CLS_SCAN,
    ST_CLS_EMIT
  } state_t;

endpackage
`default_nettype wire

>>> hdl/pbb_front.sv
`default_nettype none
module pbb_front import pbb_pkg::*; (
  input  wire      clk,
  input  wire      rst,
  input  wire      in_valid,
  output logic     in_ready,
  input  in_item_t in_data,
  output logic     q_valid,
  input  wire      q_ready,
  output job_t     q_data
);

  job_t                 q_mem [QDEPTH];
  logic [QPTR_BITS-1:0] wr_ptr, rd_ptr;
  logic [QPTR_BITS:0]   fill;
  logic                 push, pop;
  job_t                 job;

  // decode the incoming command; CMD_NONE items are accepted but never queued
  always_comb begin
    job.cmd   = cmd_t'(in_data.cmd);
    job.value = in_data.multiplicity;
  end

  assign in_ready = (fill != (QPTR_BITS+1)'(QDEPTH));
  assign push     = in_valid && in_ready && (job.cmd != CMD_NONE);
  assign q_valid  = (fill != '0);
  assign pop      = q_valid && q_ready;
  assign q_data   = q_mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) q_mem[wr_ptr] <= job;
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (push) wr_ptr <= wr_ptr + 1'b1;
      if (pop)  rd_ptr <= rd_ptr + 1'b1;
      fill <= fill + (QPTR_BITS+1)'(push) - (QPTR_BITS+1)'(pop);
    end
  end

endmodule
`default_nettype wire

>>> hdl/pbb_back.sv
`default_nettype none
module pbb_back import pbb_pkg::*; (
  input  wire        clk,
  input  wire        rst,
  input  wire        cfg_we,
  input  wire [1:0]  cfg_index,
  input  wire [63:0] cfg_data,
  input  wire        q_valid,
  output logic       q_ready,
  input  job_t       q_data,
  output logic       out_valid,
  input  wire        out_ready,
  output out_item_t  out_data
);

  // configuration
  logic [4:0]  edge_count;
  logic [63:0] edge_a, edge_b;

  always_ff @(posedge clk) begin
    if (rst) begin
      edge_count <= '0;
      edge_a     <= '0;
      edge_b     <= '0;
    end else if (cfg_we) begin
      unique case (reg_idx_t'(cfg_index))
        REG_EDGE_COUNT: edge_count <= cfg_data[4:0];
        REG_EDGE_A:     edge_a     <= cfg_data;
        REG_EDGE_B:     edge_b     <= cfg_data;
        default: ;
      endcase
    end
  end

  // sample store: one port, registered read
  logic [MULT_BITS-1:0] mem [MAX_SAMPLES];
  logic                 mem_we;
  logic [ADDR_BITS-1:0] mem_addr;
  logic [MULT_BITS-1:0] mem_wdata, mem_rdata;

  always_ff @(posedge clk) begin
    if (mem_we) mem[mem_addr] <= mem_wdata;
    mem_rdata <= mem[mem_addr];
  end

  // bin bounds live in flops (15 entries, scanned one per cycle)
  logic [MULT_BITS-1:0] bin_hi [MAX_BINS];
  logic [MULT_BITS-1:0] bin_lo [MAX_BINS];

  state_t               state, state_next;
  logic [CNT_BITS-1:0]  count;
  logic                 ovf;
  logic [3:0]           bin_total;
  logic [CNT_BITS-1:0]  si, sk;
  logic [MULT_BITS-1:0] sv;
  logic [3:0]           bi;
  logic                 bside;
  logic [4:0]           ne;
  logic [6:0]           plo, phi;
  logic [CNT_BITS+6:0]  prod;
  logic [CNT_BITS-1:0]  quot;
  logic [MULT_BITS-1:0] bhi;

  logic [4:0] ne_c;
  assign ne_c = (edge_count > 5'(MAX_EDGES)) ? 5'(MAX_EDGES) : edge_count;

  function automatic logic [6:0] edge_at(input logic [3:0] j,
                                         input logic [63:0] a,
                                         input logic [63:0] b);
    logic [63:0] w;
    logic [7:0]  e;
    w = j[3] ? b : a;
    e = w[{j[2:0], 3'b000} +: 8];
    return (e > 8'd100) ? 7'd100 : e[6:0];
  endfunction

  logic [6:0] cur_pct;
  assign cur_pct = bside ? phi : plo;

  // clamp of floor(pct*n/100) to n-1
  logic [CNT_BITS-1:0] idx_c;
  assign idx_c = (quot >= count) ? count - 1'b1 : quot;

  logic cls_hit;
  assign cls_hit = (q_data.value <= bin_hi[bi]) && (q_data.value >= bin_lo[bi]);

  logic out_free;
  assign out_free = !out_valid || out_ready;

  // a result is loaded into the output register this cycle
  logic emit;
  assign emit = out_free && (state == ST_BIN_EMIT || state == ST_CLS_EMIT);

  // sequencer: next state and store control
  always_comb begin
    state_next = state;
    q_ready    = 1'b0;
    mem_we     = 1'b0;
    mem_addr   = si[ADDR_BITS-1:0];
    mem_wdata  = q_data.value;
    unique case (state)
      ST_IDLE: begin
        mem_addr = count[ADDR_BITS-1:0];
        if (q_valid) begin
          unique case (q_data.cmd)
            CMD_ADD: begin
              q_ready = 1'b1;
              mem_we  = (count < CNT_BITS'(MAX_SAMPLES));
            end
            CMD_BUILD: begin
              if (ne_c < 5'd2 || count == '0) q_ready = 1'b1;
              else state_next = (count > CNT_BITS'(1)) ? ST_SORT_RD : ST_BIN_IDX;
            end
            CMD_CLASSIFY: state_next = (bin_total == '0) ? ST_CLS_EMIT : ST_CLS_SCAN;
            default: q_ready = 1'b1;
          endcase
        end
      end
      ST_SORT_RD:  state_next = ST_SORT_CMP;
      ST_SORT_CMP: begin
        mem_addr = ADDR_BITS'(sk - 1'b1);
        state_next = ST_SORT_SHIFT;
      end
      ST_SORT_SHIFT: begin
        mem_addr = sk[ADDR_BITS-1:0];
        if (sk != '0 && mem_rdata < sv) begin
          mem_we     = 1'b1;
          mem_wdata  = mem_rdata;
          state_next = ST_SORT_CMP;
        end else begin
          state_next = ST_SORT_PUT;
        end
      end
      ST_SORT_PUT: begin
        mem_addr  = sk[ADDR_BITS-1:0];
        mem_we    = 1'b1;
        mem_wdata = sv;
        state_next = (si + 1'b1 >= count) ? ST_BIN_IDX : ST_SORT_RD;
      end
      ST_BIN_IDX:  state_next = ST_BIN_MUL;
      ST_BIN_MUL:  state_next = ST_BIN_DIV;
      ST_BIN_DIV:  state_next = ST_BIN_RD;
      ST_BIN_RD: begin
        mem_addr = idx_c[ADDR_BITS-1:0];
        state_next = bside ? ST_BIN_EMIT : ST_BIN_IDX;
      end
      ST_BIN_EMIT: begin
        // keep the lower bound on the read port while the output stalls
        mem_addr = idx_c[ADDR_BITS-1:0];
        if (out_free) begin
          if (5'(bi) + 5'd2 == ne) begin
            q_ready = 1'b1;
            state_next = ST_IDLE;
          end else state_next = ST_BIN_IDX;
        end
      end
      ST_CLS_SCAN: begin
        if (cls_hit || bi + 1'b1 == bin_total) state_next = ST_CLS_EMIT;
      end
      ST_CLS_EMIT: begin
        if (out_free) begin
          q_ready = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // datapath registers
  logic found_r;
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      count     <= '0;
      ovf       <= 1'b0;
      bin_total <= '0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (emit) out_valid <= 1'b1;
      else if (out_ready) out_valid <= 1'b0;
      unique case (state)
        ST_IDLE: begin
          si <= CNT_BITS'(1);
          bi <= '0;
          bside <= 1'b0;
          found_r <= 1'b0;
          ne <= ne_c;
          if (q_valid && q_data.cmd == CMD_ADD) begin
            if (count < CNT_BITS'(MAX_SAMPLES)) count <= count + 1'b1;
            else ovf <= 1'b1;
          end
          if (q_valid && q_data.cmd == CMD_BUILD) bin_total <= '0;
        end
        ST_SORT_RD: sk <= si;
        ST_SORT_CMP: if (sk == si) sv <= mem_rdata;
        ST_SORT_SHIFT: if (sk != '0 && mem_rdata < sv) sk <= sk - 1'b1;
        ST_SORT_PUT: si <= si + 1'b1;
        ST_BIN_IDX: begin
          plo <= edge_at(bi, edge_a, edge_b);
          phi <= edge_at(bi + 1'b1, edge_a, edge_b);
        end
        ST_BIN_MUL: prod <= (CNT_BITS+7)'(cur_pct) * (CNT_BITS+7)'(count);
        // floor(prod/100) by reciprocal, exact for prod below 199728
        ST_BIN_DIV: quot <= CNT_BITS'((36'(prod) * 36'd167773) >> 24);
        ST_BIN_RD: bside <= ~bside;
        ST_BIN_EMIT: begin
          if (out_free) begin
            out_data  <= '{kind: 1'b0, bin_index: bi, found: 1'b0, pct_low: plo,
                           pct_high: phi, pct_mid_twice: 8'(plo) + 8'(phi),
                           bound_high: bhi, bound_low: mem_rdata,
                           sample_overflow: ovf,
                           last: (5'(bi) + 5'd2 == ne)};
            bin_hi[bi] <= bhi;
            bin_lo[bi] <= mem_rdata;
            bi <= bi + 1'b1;
            if (5'(bi) + 5'd2 == ne) bin_total <= 4'(ne - 5'd1);
          end
        end
        ST_CLS_SCAN: begin
          if (cls_hit) found_r <= 1'b1;
          else if (bi + 1'b1 != bin_total) bi <= bi + 1'b1;
        end
        ST_CLS_EMIT: begin
          if (out_free) begin
            out_data  <= '{kind: 1'b1, bin_index: found_r ? bi : 4'd0,
                           found: found_r, pct_low: 7'd0, pct_high: 7'd0,
                           pct_mid_twice: 8'd0,
                           bound_high: found_r ? bin_hi[bi] : '0,
                           bound_low: found_r ? bin_lo[bi] : '0,
                           sample_overflow: ovf, last: 1'b1};
          end
        end
        default: ;
      endcase
      // upper bound captured after first read of the pair
      if (state == ST_BIN_IDX && bside) bhi <= mem_rdata;
    end
  end

endmodule
`default_nettype wire

>>> hdl/percentile_bin_builder_classifier.sv
`default_nettype none
// Percentile bin builder and classifier. Add-sample commands are taken one
// per cycle while the four-entry command queue has room, and written to a
// single-port 1024-entry sample store at one per cycle while the back end is
// idle. A build command insertion-sorts the store largest first, reading each
// sample, shifting smaller ones along and putting it in place, then reads the
// two bounds of each bin. A classify command scans the stored bins at one per
// cycle until one holds the value or the last is reached. Results leave
// through a registered output stage.
module percentile_bin_builder_classifier import pbb_pkg::*; (
  input  wire        clk,
  input  wire        rst,
  input  wire        cfg_we,
  input  wire [1:0]  cfg_index,
  input  wire [63:0] cfg_data,
  input  wire        in_valid,
  output logic       in_ready,
  input  in_item_t   in_data,
  output logic       out_valid,
  input  wire        out_ready,
  output out_item_t  out_data
);

  logic q_valid, q_ready;
  job_t q_data;

  pbb_front u_front (
    .clk, .rst, .in_valid, .in_ready, .in_data,
    .q_valid, .q_ready, .q_data
  );

  pbb_back u_back (
    .clk, .rst, .cfg_we, .cfg_index, .cfg_data,
    .q_valid, .q_ready, .q_data,
    .out_valid, .out_ready, .out_data
  );

endmodule
`default_nettype wire

>>> tb/sv/percentile_bin_builder_classifier_tb.sv
`default_nettype none
module percentile_bin_builder_classifier_tb;
  import pbb_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  // Scoreboard: mirrors the sample store and bins, queues expected records
  class bin_scoreboard;
    bit [15:0] samples [MAX_SAMPLES];
    int unsigned count;
    bit ovf;
    bit [15:0] upper [MAX_BINS];
    bit [15:0] lower [MAX_BINS];
    int unsigned nbins;
    bit [4:0] ecount;
    bit [63:0] ea, eb;
    out_item_t pending[$];
    int errors;
    int records, answers, hits;

    function void set_reg(reg_idx_t idx, bit [63:0] v);
      case (idx)
        REG_EDGE_COUNT: ecount = v[4:0];
        REG_EDGE_A:     ea = v;
        REG_EDGE_B:     eb = v;
        default: ;
      endcase
    endfunction

    function bit [6:0] edge_pct(int j);
      bit [7:0] e;
      e = (j < 8) ? ea[8*j +: 8] : eb[8*(j-8) +: 8];
      return (e > 100) ? 7'd100 : e[6:0];
    endfunction

    function int unsigned pos_of(bit [6:0] pct);
      int unsigned p;
      p = (pct * count) / 100;
      return (p >= count) ? count - 1 : p;
    endfunction

    function out_item_t blank();
      out_item_t r;
      r = '0;
      r.sample_overflow = ovf;
      return r;
    endfunction

    // Work out the records caused by one accepted command
    function void note_input(in_item_t it);
      int unsigned ne, k;
      bit [15:0] v;
      out_item_t r;
      case (cmd_t'(it.cmd))
        CMD_ADD: begin
          if (count < MAX_SAMPLES) begin
            samples[count] = it.multiplicity;
            count++;
          end else ovf = 1;
        end
        CMD_BUILD: begin
          ne = (ecount > MAX_EDGES) ? MAX_EDGES : ecount;
          nbins = 0;
          if (ne >= 2 && count > 0) begin
            // largest first
            for (int i = 1; i < count; i++) begin
              v = samples[i];
              k = i;
              while (k > 0 && samples[k-1] < v) begin
                samples[k] = samples[k-1];
                k--;
              end
              samples[k] = v;
            end
            for (int i = 0; i + 1 < ne; i++) begin
              r = blank();
              r.bin_index = 4'(i);
              r.pct_low = edge_pct(i);
              r.pct_high = edge_pct(i+1);
              r.pct_mid_twice = r.pct_low + r.pct_high;
              upper[i] = samples[pos_of(r.pct_low)];
              lower[i] = samples[pos_of(r.pct_high)];
              r.bound_high = upper[i];
              r.bound_low = lower[i];
              r.last = (i + 2 == ne);
              pending.insert(pending.size(), r);
            end
            nbins = ne - 1;
          end
        end
        CMD_CLASSIFY: begin
          r = blank();
          r.kind = 1;
          r.last = 1;
          for (int i = 0; i < nbins; i++)
            if (it.multiplicity <= upper[i] && it.multiplicity >= lower[i]) begin
              r.bin_index = 4'(i);
              r.found = 1;
              r.bound_high = upper[i];
              r.bound_low = lower[i];
              break;
            end
          pending.insert(pending.size(), r);
        end
        default: ;
      endcase
    endfunction

    function void report(string what, longint got, longint want);
      $display("[%0t] mismatch on %s: got %0h, expected %0h", $time, what, got, want);
      errors++;
    endfunction

    function void check_result(out_item_t got);
      out_item_t w;
      if (pending.size() == 0) begin
        report("unexpected record", got, 0);
        return;
      end
      w = pending.pop_front();
      if (w.kind) begin
        answers++;
        if (w.found) hits++;
      end else records++;
      if (got.kind != w.kind) report("kind", got.kind, w.kind);
      if (got.bin_index != w.bin_index) report("bin_index", got.bin_index, w.bin_index);
      if (got.found != w.found) report("found", got.found, w.found);
      if (got.pct_low != w.pct_low) report("pct_low", got.pct_low, w.pct_low);
      if (got.pct_high != w.pct_high) report("pct_high", got.pct_high, w.pct_high);
      if (got.pct_mid_twice != w.pct_mid_twice)
        report("pct_mid_twice", got.pct_mid_twice, w.pct_mid_twice);
      if (got.bound_high != w.bound_high) report("bound_high", got.bound_high, w.bound_high);
      if (got.bound_low != w.bound_low) report("bound_low", got.bound_low, w.bound_low);
      if (got.sample_overflow != w.sample_overflow)
        report("sample_overflow", got.sample_overflow, w.sample_overflow);
      if (got.last != w.last) report("last", got.last, w.last);
    endfunction
  endclass

  logic clk, rst;
  logic cfg_we;
  logic [1:0] cfg_index;
  logic [63:0] cfg_data;
  logic in_valid, in_ready;
  in_item_t in_data;
  logic out_valid, out_ready;
  out_item_t out_data;

  bin_scoreboard sb;
  int hold_left;
  bit burst_mode;

  percentile_bin_builder_classifier dut (
    .clk(clk), .rst(rst),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data)
  );

  initial begin
    clk = 0;
    forever #6 clk = ~clk;
  end

  initial begin
    #(12ns * 3_000_000);
    $display("Timeout");
    $display("Mismatches found");
    $finish;
  end

  function int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (burst_mode || r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // Receiver: random stalls, a forced hold-off when requested, or always ready in burst mode
  always @(negedge clk) begin
    if (rst) out_ready <= 0;
    else if (hold_left > 0) begin
      out_ready <= 0;
      hold_left <= hold_left - 1;
    end else if (burst_mode) out_ready <= 1;
    else out_ready <= (pick_gap() == 0);
  end

  always @(posedge clk)
    if (!rst && out_valid && out_ready) sb.check_result(out_data);

  task automatic send(cmd_t c, bit [15:0] v);
    int g;
    in_valid <= 1;
    in_data <= '{cmd: c, multiplicity: v};
    do @(posedge clk); while (!in_ready);
    sb.note_input(in_data);
    @(negedge clk);
    g = pick_gap();
    if (g > 0) begin
      in_valid <= 0;
      repeat (g) @(negedge clk);
    end
  endtask

  // Wait for every expected record; a classify flushes any silent work first
  task automatic drain();
    in_valid <= 0;
    @(negedge clk);
    send(CMD_CLASSIFY, 16'($urandom));
    in_valid <= 0;
    while (sb.pending.size() != 0) @(negedge clk);
    repeat (20) @(negedge clk);
  endtask

  task automatic write_reg(reg_idx_t idx, bit [63:0] v);
    cfg_we <= 1;
    cfg_index <= idx;
    cfg_data <= v;
    sb.set_reg(idx, v);
    @(negedge clk);
    cfg_we <= 0;
  endtask

  task automatic set_edges(bit [4:0] n, bit [63:0] a, bit [63:0] b);
    write_reg(REG_EDGE_COUNT, n);
    write_reg(REG_EDGE_A, a);
    write_reg(REG_EDGE_B, b);
  endtask

  function bit [15:0] near_sample();
    if (sb.count == 0 || $urandom_range(0, 3) == 0) return 16'($urandom);
    return 16'(sb.samples[$urandom_range(0, sb.count - 1)] + $urandom_range(0, 2) - 1);
  endfunction

  task automatic random_items(int n);
    int r;
    for (int i = 0; i < n; i++) begin
      r = $urandom_range(0, 99);
      if (r < 45) send(CMD_ADD, 16'($urandom));
      else if (r < 55) send(CMD_BUILD, 16'($urandom));
      else if (r < 95) send(CMD_CLASSIFY, near_sample());
      else send(CMD_NONE, 16'($urandom));
    end
  endtask

  initial begin
    sb = new();
    rst = 1;
    cfg_we = 0;
    cfg_index = REG_EDGE_COUNT;
    cfg_data = '0;
    in_valid = 0;
    in_data = '0;
    hold_left = 0;
    burst_mode = 0;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst = 0;

    // Directed: no bins, empty store, extremes, ignored command
    send(CMD_CLASSIFY, 16'h0000);
    send(CMD_BUILD, 16'hFFFF);
    send(CMD_NONE, 16'hFFFF);
    drain();
    set_edges(5'd2, 64'h0000_0000_0000_6400, 64'h0);
    send(CMD_BUILD, 16'h0);
    send(CMD_ADD, 16'hFFFF);
    send(CMD_ADD, 16'h0000);
    send(CMD_ADD, 16'h5555);
    send(CMD_ADD, 16'hAAAA);
    send(CMD_ADD, 16'h0001);
    send(CMD_ADD, 16'h8000);
    send(CMD_BUILD, 16'h0);
    send(CMD_CLASSIFY, 16'hFFFF);
    send(CMD_CLASSIFY, 16'h0000);
    drain();
    // single edge: clears bins
    set_edges(5'd1, 64'h32, 64'h0);
    send(CMD_BUILD, 16'h0);
    send(CMD_CLASSIFY, 16'h5555);
    drain();
    // count above table size, bytes above 100, not ascending
    set_edges(5'd31, 64'hFF65_6400_3219_0A00, 64'h0501_6450_C864_1E0F);
    send(CMD_BUILD, 16'h0);
    send(CMD_CLASSIFY, 16'h8000);
    send(CMD_CLASSIFY, 16'h1234);
    drain();

    // Random phases under several edge settings
    set_edges(5'd5, 64'h64_4B_32_19_00, 64'h0);
    random_items(105);
    drain();
    set_edges(5'd16, {$urandom, $urandom}, {$urandom, $urandom});
    random_items(105);
    drain();
    set_edges(5'd16, 64'h46_3C_32_28_1E_14_0A_00, 64'h64_64_5F_5A_55_50_50_4B);
    random_items(105);

    // Hold the receiver while the sender keeps offering
    send(CMD_BUILD, 16'h0);
    hold_left = 400;
    for (int i = 0; i < 20; i++) send(CMD_CLASSIFY, near_sample());
    drain();

    // Back-to-back small samples, then build with new edges
    burst_mode = 1;
    for (int i = 0; i < 10; i++) send(CMD_ADD, 16'h0000);
    burst_mode = 0;
    drain();
    set_edges(5'd4, 64'h64_63_01_00, 64'h0);
    send(CMD_BUILD, 16'h0);
    send(CMD_CLASSIFY, 16'h0000);
    send(CMD_CLASSIFY, 16'hFFFF);
    in_valid <= 0;

    while (sb.pending.size() != 0) @(negedge clk);
    repeat (200) @(negedge clk);
    $display("Covered %0d bin records and %0d classify answers (%0d hits), %0d samples held",
             sb.records, sb.answers, sb.hits, sb.count);
    $display("Overflow flag set: %0d, mismatches: %0d", sb.ovf, sb.errors);
    if (sb.errors == 0) $display("No mismatches found");
    else $display("Mismatches found");
    $finish;
  end
endmodule
`default_nettype wire

>>> sim.f
hdl/pbb_pkg.sv
hdl/pbb_front.sv
hdl/pbb_back.sv
hdl/percentile_bin_builder_classifier.sv
tb/sv/percentile_bin_builder_classifier_tb.sv
